@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/sspr_pkg.sv @@
// ----------------------------------------------------------------------------
// sspr_pkg
// shared types and codes of the servo status packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sspr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] SYNC_BYTE = 8'hFF;

  // input kinds
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // end-of-packet status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_CHECKSUM = 2'd1;
  localparam logic [StatusW-1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [StatusW-1:0] ST_LENGTH   = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               last;
    logic [ByteW-1:0]   param_byte;
    logic [ByteW-1:0]   param_index;
    logic [ByteW-1:0]   error_flags;
    logic [ByteW-1:0]   servo_id;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/sspr_core.sv @@
// ----------------------------------------------------------------------------
// sspr_core
// packet phase tracking, running checksum and result forming
// ----------------------------------------------------------------------------
`default_nettype none

module sspr_core
  import sspr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             op,
  input  wire logic [ByteW-1:0] rx_byte,
  output logic                  res_valid,
  output result_t               res
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_CHK   = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [ByteW-1:0] packet_id, packet_id_next;
  logic [ByteW-1:0] packet_length, packet_length_next;
  logic [ByteW-1:0] packet_error, packet_error_next;
  logic [ByteW-1:0] param_count, param_count_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [ByteW-1:0] count_inc;
  logic [ByteW:0]   count_plus2;

  assign count_inc   = param_count + 8'd1;
  assign count_plus2 = {1'b0, count_inc} + 9'd2;

  always_comb begin
    phase_next         = phase;
    packet_id_next     = packet_id;
    packet_length_next = packet_length;
    packet_error_next  = packet_error;
    param_count_next   = param_count;
    running_sum_next   = running_sum;
    res_valid          = 1'b0;
    res.servo_id       = packet_id;
    res.error_flags    = packet_error;
    res.param_index    = param_count;
    res.param_byte     = '0;
    res.status         = ST_OK;
    res.last           = 1'b1;

    if (op == OP_TIMEOUT) begin
      res_valid  = 1'b1;
      res.status = ST_TIMEOUT;
      phase_next = PH_SYNC1;
    end else begin
      case (phase)
        PH_SYNC1: begin
          if (rx_byte == SYNC_BYTE) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == SYNC_BYTE) begin
            phase_next         = PH_ID;
            packet_id_next     = '0;
            packet_length_next = '0;
            packet_error_next  = '0;
            param_count_next   = '0;
            running_sum_next   = '0;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_ID: begin
          packet_id_next   = rx_byte;
          running_sum_next = rx_byte;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          packet_length_next = rx_byte;
          if (rx_byte < 8'd2) begin
            // too short to hold the error and checksum bytes
            res_valid       = 1'b1;
            res.param_index = '0;
            res.status      = ST_LENGTH;
            phase_next      = PH_SYNC1;
          end else begin
            running_sum_next = running_sum + rx_byte;
            phase_next       = PH_ERR;
          end
        end
        PH_ERR: begin
          packet_error_next = rx_byte;
          running_sum_next  = running_sum + rx_byte;
          phase_next        = (packet_length > 8'd2) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          res_valid        = 1'b1;
          res.param_byte   = rx_byte;
          res.last         = 1'b0;
          running_sum_next = running_sum + rx_byte;
          param_count_next = count_inc;
          if (count_plus2 >= {1'b0, packet_length}) phase_next = PH_CHK;
        end
        PH_CHK: begin
          res_valid  = 1'b1;
          res.status = (rx_byte == ~running_sum) ? ST_OK : ST_CHECKSUM;
          phase_next = PH_SYNC1;
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      packet_id     <= '0;
      packet_length <= '0;
      packet_error  <= '0;
      param_count   <= '0;
      running_sum   <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      packet_id     <= packet_id_next;
      packet_length <= packet_length_next;
      packet_error  <= packet_error_next;
      param_count   <= param_count_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sspr_out_reg.sv @@
// ----------------------------------------------------------------------------
// sspr_out_reg
// result register holding one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module sspr_out_reg
  import sspr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    take,
  output logic         valid,
  output result_t      data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/servo_status_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// servo_status_packet_receiver
// status packet parser for half-duplex servo bus replies
// ----------------------------------------------------------------------------
// Takes one received byte (tuser 0) or one read-timeout event (tuser 1) per
// transfer. It hunts for two 0xFF sync bytes, then reads id, length, error
// byte, length-2 parameter bytes and the checksum (inverted 8-bit sum of id,
// length, error and parameters). Every parameter byte comes out as a result
// with tlast low; the checksum byte gives a tlast result with status ok or
// checksum error. A timeout gives a tlast result with status timeout at any
// point, and a length below 2 a tlast result with status length error; both
// go back to hunting. Throughput is one transfer per clock while m_tready keeps
// the output register draining: the input register feeds a single pass of phase
// and checksum logic whose result lands in the output register, so a byte passes
// both registers before its result is on m_tdata. The input side accepts while
// a result waits, stalling only when both registers are full and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module servo_status_packet_receiver
  import sspr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [ByteW-1:0]     s_tdata,   // [7:0] rx_byte
  input  wire logic                 s_tuser,   // [0] op
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [4*ByteW-1:0]        m_tdata,   // [7:0] servo_id, [15:8] error_flags,
                                               // [23:16] param_index, [31:24] param_byte
  output logic [StatusW-1:0]        m_tuser,   // [1:0] status
  output logic                      m_tlast
);

  // input register
  logic             in_valid;
  logic             in_op;
  logic [ByteW-1:0] in_byte;
  logic             step;      // step logic consumes the held item
  logic             s_xfer;

  // step results
  logic    res_valid;
  result_t res;
  result_t out_data;

  // the held item moves on whenever the result register is free or draining
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;
  assign s_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // phase tracking and checksum
  sspr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (step),
    .op        (in_op),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  sspr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_data (res),
    .take      (m_tready),
    .valid     (m_tvalid),
    .data      (out_data)
  );

  assign m_tdata = {out_data.param_byte, out_data.param_index,
                    out_data.error_flags, out_data.servo_id};
  assign m_tuser = out_data.status;
  assign m_tlast = out_data.last;

  // a timeout always yields a timeout status result
  `ASSERT_NEXT(a_timeout_result, clk, rst, step && (in_op == OP_TIMEOUT),
               m_tvalid && m_tlast && (m_tuser == ST_TIMEOUT))
  // parameter results never carry a status
  `ASSERT_IMPLY(a_param_status, clk, rst, m_tvalid && !m_tlast, m_tuser == ST_OK)
  // input only stalls when both registers are full and the output is blocked
  `ASSERT_IMPLY(a_stall_cause, clk, rst, !s_tready, in_valid && m_tvalid && !m_tready)
  // a held item that cannot step stays held
  `ASSERT_NEXT(a_hold_item, clk, rst, in_valid && !step, in_valid)

endmodule

`default_nettype wire
